// ===== sv/qau_pkg.sv =====
// ----------------------------------------------------------------------------
// qau_pkg
// Shared constants and types for the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

    localparam int FRAC_BITS = 12;

    // operation codes
    localparam logic [1:0] KIND_PROD = 2'd0;
    localparam logic [1:0] KIND_CONJ = 2'd1;
    localparam logic [1:0] KIND_NORM = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_SAT  = 2'd1;
    localparam logic [1:0] STAT_ZERO = 2'd2;

    // square root: 33-bit radicand, 17-bit root
    localparam int RB = 17;
    localparam int SW = 34;
    // division: quotient never exceeds 2^FRAC_BITS
    localparam int QB = FRAC_BITS + 1;
    localparam int CW = FRAC_BITS + 19;

    // stage numbering
    localparam int STG_SQRT0 = 3;
    localparam int STG_PREP  = STG_SQRT0 + RB;
    localparam int STG_DIV0  = STG_PREP + 1;
    localparam int STG_OUT   = STG_DIV0 + QB;
    localparam int NST       = STG_OUT + 1;
    localparam int NCM       = STG_OUT - 2;

    typedef logic signed [15:0] comp_t;

    typedef struct packed {
        logic [1:0]      kind;
        comp_t [3:0]     a;
        comp_t [3:0]     res;
        logic [1:0]      status;
    } cm_t;

    // saturate to 16 bits, msb of result is the overflow flag
    function automatic logic [16:0] sat16(input logic signed [34:0] v);
        if (v > 35'sd32767) begin
            return {1'b1, 16'h7FFF};
        end else if (v < -35'sd32768) begin
            return {1'b1, 16'h8000};
        end else begin
            return {1'b0, v[15:0]};
        end
    endfunction

endpackage

// ===== sv/quaternion_arith_unit_top.sv =====
// ----------------------------------------------------------------------------
// quaternion_arith_unit_top
// Pipelined Q3.12 quaternion unit: Hamilton product, conjugate, normalize.
// ----------------------------------------------------------------------------
//  channel  | ports                          | dir
//  request  | s_valid s_ready s_kind s_a_* s_b_* | in
//  result   | m_valid m_ready m_res_* m_status   | out
//
//  One item per cycle sustained while m_ready is held high; the depth of the
//  pipeline is set by the square root (one root bit per stage) followed by the
//  restoring divider (one quotient bit per stage, four lanes).
//  aresetn clears the valid bit of every stage; data registers are not reset.
//  A stage holds when the one after it is full and not moving; bubbles close
//  up, so input is taken while a result waits at the output.
// ----------------------------------------------------------------------------
module quaternion_arith_unit_top
    import qau_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic signed [15:0] s_a_w,
    input  logic signed [15:0] s_a_x,
    input  logic signed [15:0] s_a_y,
    input  logic signed [15:0] s_a_z,
    input  logic signed [15:0] s_b_w,
    input  logic signed [15:0] s_b_x,
    input  logic signed [15:0] s_b_y,
    input  logic signed [15:0] s_b_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_res_w,
    output logic signed [15:0] m_res_x,
    output logic signed [15:0] m_res_y,
    output logic signed [15:0] m_res_z,
    output logic [1:0]         m_status
);

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] free;

    // stage 0: input capture
    logic [1:0]         in_kind_reg;
    logic signed [15:0] in_a_reg [4];
    logic signed [15:0] in_b_reg [4];
    // stage 1: products and squares
    logic [1:0]         mul_kind_reg;
    logic signed [15:0] mul_a_reg [4];
    logic signed [31:0] prod_reg [4][4];
    logic [31:0]        sqr_reg [4];
    // stage 2 onward
    cm_t                cm_reg [NCM];
    cm_t                cm_next;
    logic [SW-1:0]      sq_rem_reg [RB+1];
    logic [RB-1:0]      sq_root_reg [RB+1];
    logic [SW-1:0]      sq_sum_next;
    logic [CW-1:0]      dv_rem_reg [QB+1][4];
    logic [QB-1:0]      dv_q_reg [QB+1][4];
    logic [RB:0]        dv_d_reg [QB+1];
    logic [CW-1:0]      dv_rem_next [4];
    // output
    logic signed [15:0] out_res_reg [4];
    logic [1:0]         out_status_reg;
    logic signed [15:0] out_res_next [4];
    logic [1:0]         out_status_next;

    // ---------------- flow control ----------------
    always_comb begin
        for (int k = NST - 1; k >= 0; k--) begin
            if (k == NST - 1) begin
                free[k] = !vld_reg[k] || m_ready;
            end else begin
                free[k] = !vld_reg[k] || free[k+1];
            end
        end
    end

    assign s_ready = free[0];
    assign m_valid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (free[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (free[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 0 ----------------
    always_ff @(posedge aclk) begin
        if (free[0]) begin
            in_kind_reg <= s_kind;
            in_a_reg[0] <= s_a_w;
            in_a_reg[1] <= s_a_x;
            in_a_reg[2] <= s_a_y;
            in_a_reg[3] <= s_a_z;
            in_b_reg[0] <= s_b_w;
            in_b_reg[1] <= s_b_x;
            in_b_reg[2] <= s_b_y;
            in_b_reg[3] <= s_b_z;
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge aclk) begin
        if (free[1]) begin
            mul_kind_reg <= in_kind_reg;
            for (int i = 0; i < 4; i++) begin
                mul_a_reg[i] <= in_a_reg[i];
                sqr_reg[i]   <= unsigned'(32'(in_a_reg[i]) * 32'(in_a_reg[i]));
                for (int j = 0; j < 4; j++) begin
                    prod_reg[i][j] <= in_a_reg[i] * in_b_reg[j];
                end
            end
        end
    end

    // ---------------- stage 2: sums, round, conjugate, sum of squares ----------------
    logic signed [33:0] psum [4];
    logic signed [34:0] prnd [4];
    logic [16:0]        psat [4];
    logic [16:0]        nsat [4];

    always_comb begin
        psum[0] = 34'(prod_reg[0][0]) - 34'(prod_reg[1][1])
                - 34'(prod_reg[2][2]) - 34'(prod_reg[3][3]);
        psum[1] = 34'(prod_reg[0][1]) + 34'(prod_reg[1][0])
                + 34'(prod_reg[2][3]) - 34'(prod_reg[3][2]);
        psum[2] = 34'(prod_reg[0][2]) - 34'(prod_reg[1][3])
                + 34'(prod_reg[2][0]) + 34'(prod_reg[3][1]);
        psum[3] = 34'(prod_reg[0][3]) + 34'(prod_reg[1][2])
                - 34'(prod_reg[2][1]) + 34'(prod_reg[3][0]);
        for (int i = 0; i < 4; i++) begin
            // round half up, floor shift
            prnd[i] = (35'(psum[i]) + $signed(35'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
            psat[i] = sat16(prnd[i]);
            nsat[i] = sat16(-35'(mul_a_reg[i]));
        end

        sq_sum_next = SW'(sqr_reg[0]) + SW'(sqr_reg[1]) + SW'(sqr_reg[2])
                    + SW'(sqr_reg[3]);

        cm_next.kind = mul_kind_reg;
        for (int i = 0; i < 4; i++) begin
            cm_next.a[i] = mul_a_reg[i];
        end
        case (mul_kind_reg)
            KIND_PROD: begin
                for (int i = 0; i < 4; i++) begin
                    cm_next.res[i] = psat[i][15:0];
                end
                cm_next.status = (psat[0][16] | psat[1][16] | psat[2][16] | psat[3][16])
                               ? STAT_SAT : STAT_OK;
            end
            KIND_NORM: begin
                for (int i = 0; i < 4; i++) begin
                    cm_next.res[i] = mul_a_reg[i];
                end
                cm_next.status = (sq_sum_next == '0) ? STAT_ZERO : STAT_OK;
            end
            default: begin
                // conjugate; the unused code behaves the same
                cm_next.res[0] = mul_a_reg[0];
                for (int i = 1; i < 4; i++) begin
                    cm_next.res[i] = nsat[i][15:0];
                end
                cm_next.status = (nsat[1][16] | nsat[2][16] | nsat[3][16])
                               ? STAT_SAT : STAT_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (free[2]) begin
            cm_reg[0]      <= cm_next;
            sq_rem_reg[0]  <= sq_sum_next;
            sq_root_reg[0] <= '0;
        end
    end

    // common fields ride along with the arithmetic stages
    for (genvar c = 1; c < NCM; c++) begin : g_cm
        always_ff @(posedge aclk) begin
            if (free[c+2]) begin
                cm_reg[c] <= cm_reg[c-1];
            end
        end
    end

    // ---------------- square root, one bit per stage ----------------
    for (genvar j = 0; j < RB; j++) begin : g_sqrt
        localparam int BIT = RB - 1 - j;
        logic [SW-1:0] trial;

        assign trial = (SW'(sq_root_reg[j]) << (BIT + 1)) + (SW'(1) << (2 * BIT));

        always_ff @(posedge aclk) begin
            if (free[STG_SQRT0+j]) begin
                if (sq_rem_reg[j] >= trial) begin
                    sq_rem_reg[j+1]  <= sq_rem_reg[j] - trial;
                    sq_root_reg[j+1] <= sq_root_reg[j] | (RB'(1) << BIT);
                end else begin
                    sq_rem_reg[j+1]  <= sq_rem_reg[j];
                    sq_root_reg[j+1] <= sq_root_reg[j];
                end
            end
        end
    end

    // ---------------- divider setup ----------------
    // q = (2*|c|*2^F + r) / (2r): round half away from zero on the magnitude
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            logic [16:0] neg;
            logic [15:0] mag;
            neg = -17'(cm_reg[RB].a[i]);
            mag = cm_reg[RB].a[i][15] ? neg[15:0] : cm_reg[RB].a[i];
            dv_rem_next[i] = (CW'(mag) << (FRAC_BITS + 1)) + CW'(sq_root_reg[RB]);
        end
    end

    always_ff @(posedge aclk) begin
        if (free[STG_PREP]) begin
            dv_d_reg[0] <= {sq_root_reg[RB], 1'b0};
            for (int i = 0; i < 4; i++) begin
                dv_rem_reg[0][i] <= dv_rem_next[i];
                dv_q_reg[0][i]   <= '0;
            end
        end
    end

    // ---------------- restoring divide, four lanes ----------------
    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int BIT = QB - 1 - k;
        logic [CW-1:0] dsh;

        assign dsh = CW'(dv_d_reg[k]) << BIT;

        always_ff @(posedge aclk) begin
            if (free[STG_DIV0+k]) begin
                dv_d_reg[k+1] <= dv_d_reg[k];
                for (int i = 0; i < 4; i++) begin
                    if (dv_rem_reg[k][i] >= dsh) begin
                        dv_rem_reg[k+1][i] <= dv_rem_reg[k][i] - dsh;
                        dv_q_reg[k+1][i]   <= dv_q_reg[k][i] | (QB'(1) << BIT);
                    end else begin
                        dv_rem_reg[k+1][i] <= dv_rem_reg[k][i];
                        dv_q_reg[k+1][i]   <= dv_q_reg[k][i];
                    end
                end
            end
        end
    end

    // ---------------- output ----------------
    always_comb begin
        logic [16:0]        qs [4];
        logic signed [34:0] qv;
        cm_t                cm;
        cm = cm_reg[NCM-1];
        for (int i = 0; i < 4; i++) begin
            qv    = $signed(35'(dv_q_reg[QB][i]));
            qs[i] = sat16(cm.a[i][15] ? -qv : qv);
        end
        if (cm.kind == KIND_NORM && cm.status != STAT_ZERO) begin
            for (int i = 0; i < 4; i++) begin
                out_res_next[i] = qs[i][15:0];
            end
            out_status_next = (qs[0][16] | qs[1][16] | qs[2][16] | qs[3][16])
                            ? STAT_SAT : STAT_OK;
        end else begin
            for (int i = 0; i < 4; i++) begin
                out_res_next[i] = cm.res[i];
            end
            out_status_next = cm.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (free[STG_OUT]) begin
            for (int i = 0; i < 4; i++) begin
                out_res_reg[i] <= out_res_next[i];
            end
            out_status_reg <= out_status_next;
        end
    end

    assign m_res_w  = out_res_reg[0];
    assign m_res_x  = out_res_reg[1];
    assign m_res_y  = out_res_reg[2];
    assign m_res_z  = out_res_reg[3];
    assign m_status = out_status_reg;

`ifndef NO_ASSERTIONS
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3)
        else $error("illegal status code");

    a_in_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted request not captured");

    a_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_ZERO |->
            m_res_w == '0 && m_res_x == '0 && m_res_y == '0 && m_res_z == '0)
        else $error("zero magnitude with nonzero result");

    a_root_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[STG_PREP-1] && cm_reg[RB].kind == KIND_NORM
            && cm_reg[RB].status != STAT_ZERO |-> sq_root_reg[RB] != '0)
        else $error("zero root for nonzero radicand");
`endif

endmodule

// ===== bench/quaternion_arith_unit_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arith_unit_top_test
// Self-checking bench, random flow control: a directed table of corner
// requests, then random ones, against literals or a behavioral quaternion model.
// ----------------------------------------------------------------------------
module quaternion_arith_unit_top_test
    import qau_pkg::*;
();

    localparam logic [1:0] KIND_UNDEF = 2'd3;
    localparam int N_RANDOM = 1700;

    typedef struct {
        logic [1:0] kind;
        comp_t      a[4];   // w x y z
        comp_t      b[4];
    } quat_req_t;

    typedef struct {
        comp_t      q[4];
        logic [1:0] status;
    } quat_res_t;

    // directed row: expected result given only where lit is set
    typedef struct {
        logic [1:0] kind;
        int         a[4];
        int         b[4];
        bit         lit;
        int         r[4];
        logic [1:0] st;
    } dir_row_t;

    localparam int N_DIR = 18;
    dir_row_t dir_rows[N_DIR] = '{
        '{KIND_CONJ, '{1, 2, 3, 4}, '{9, 9, 9, 9}, 1, '{1, -2, -3, -4}, STAT_OK},
        '{KIND_CONJ, '{0, -32768, 0, 0}, '{0, 0, 0, 0}, 1, '{0, 32767, 0, 0}, STAT_SAT},
        '{KIND_UNDEF, '{-32768, 32767, -32768, 5}, '{1, 1, 1, 1}, 1,
          '{-32768, -32767, 32767, -5}, STAT_SAT},
        '{KIND_NORM, '{0, 0, 0, 0}, '{-32768, 32767, -1, 1}, 1, '{0, 0, 0, 0}, STAT_ZERO},
        '{KIND_NORM, '{4096, 0, 0, 0}, '{0, 0, 0, 0}, 1, '{4096, 0, 0, 0}, STAT_OK},
        '{KIND_NORM, '{-32768, 0, 0, 0}, '{0, 0, 0, 0}, 1, '{-4096, 0, 0, 0}, STAT_OK},
        '{KIND_NORM, '{1, 0, 0, 0}, '{0, 0, 0, 0}, 1, '{4096, 0, 0, 0}, STAT_OK},
        '{KIND_NORM, '{-1, 0, 0, 0}, '{0, 0, 0, 0}, 1, '{-4096, 0, 0, 0}, STAT_OK},
        '{KIND_NORM, '{1, 1, 1, 1}, '{0, 0, 0, 0}, 1, '{2048, 2048, 2048, 2048}, STAT_OK},
        '{KIND_NORM, '{32767, 32767, 32767, 32767}, '{0, 0, 0, 0}, 0, '{0, 0, 0, 0}, STAT_OK},
        '{KIND_NORM, '{-32768, -32768, -32768, -32768}, '{0, 0, 0, 0}, 0,
          '{0, 0, 0, 0}, STAT_OK},
        '{KIND_PROD, '{4096, 0, 0, 0}, '{100, -200, 300, -400}, 1,
          '{100, -200, 300, -400}, STAT_OK},
        '{KIND_PROD, '{0, 0, 0, 0}, '{0, 0, 0, 0}, 1, '{0, 0, 0, 0}, STAT_OK},
        '{KIND_PROD, '{1, 0, 0, 0}, '{2048, 0, 0, 0}, 1, '{1, 0, 0, 0}, STAT_OK},
        '{KIND_PROD, '{1, 0, 0, 0}, '{-2049, 0, 0, 0}, 0, '{0, 0, 0, 0}, STAT_OK},
        '{KIND_PROD, '{-32768, -32768, -32768, -32768}, '{-32768, -32768, -32768, -32768},
          0, '{0, 0, 0, 0}, STAT_OK},
        '{KIND_PROD, '{32767, 32767, 32767, 32767}, '{-32768, -32768, -32768, -32768},
          0, '{0, 0, 0, 0}, STAT_OK},
        '{KIND_PROD, '{32767, -32768, 32767, -32768}, '{32767, 32767, -32768, 32767},
          0, '{0, 0, 0, 0}, STAT_OK}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = '0;
    comp_t       s_a_w = '0, s_a_x = '0, s_a_y = '0, s_a_z = '0;
    comp_t       s_b_w = '0, s_b_x = '0, s_b_y = '0, s_b_z = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    comp_t       m_res_w, m_res_x, m_res_y, m_res_z;
    logic [1:0]  m_status;

    quat_res_t   pending_results[$];
    int          n_errors = 0;
    int          n_results = 0;
    int          n_sat = 0;
    int          n_zero = 0;
    int          n_kind[4] = '{0, 0, 0, 0};

    quaternion_arith_unit_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_a_w(s_a_w), .s_a_x(s_a_x), .s_a_y(s_a_y), .s_a_z(s_a_z),
        .s_b_w(s_b_w), .s_b_x(s_b_x), .s_b_y(s_b_y), .s_b_z(s_b_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_res_w(m_res_w), .m_res_x(m_res_x), .m_res_y(m_res_y), .m_res_z(m_res_z),
        .m_status(m_status)
    );

    always #5 aclk = ~aclk;

    function automatic comp_t clamp16(input longint v, inout bit ovf);
        if (v > 32767) begin
            ovf = 1'b1;
            return 16'sh7FFF;
        end else if (v < -32768) begin
            ovf = 1'b1;
            return 16'sh8000;
        end
        return comp_t'(v);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned s);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= root + bitv) begin
                s = s - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic quat_res_t quat_compute(input quat_req_t rq);
        quat_res_t      res;
        longint         aw, ax, ay, az, bw, bx, by, bz;
        longint         acc[4];
        longint unsigned sum_sq, mag, scaled, quo;
        bit             ovf;
        ovf = 1'b0;
        res.status = STAT_OK;
        aw = rq.a[0]; ax = rq.a[1]; ay = rq.a[2]; az = rq.a[3];
        bw = rq.b[0]; bx = rq.b[1]; by = rq.b[2]; bz = rq.b[3];
        if (rq.kind == KIND_PROD) begin
            acc[0] = aw * bw - ax * bx - ay * by - az * bz;
            acc[1] = aw * bx + ax * bw + ay * bz - az * by;
            acc[2] = aw * by - ax * bz + ay * bw + az * bx;
            acc[3] = aw * bz + ax * by - ay * bx + az * bw;
            for (int i = 0; i < 4; i++)
                res.q[i] = clamp16((acc[i] + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS, ovf);
        end else if (rq.kind == KIND_NORM) begin
            sum_sq = aw * aw + ax * ax + ay * ay + az * az;
            for (int i = 0; i < 4; i++) res.q[i] = rq.a[i];
            if (sum_sq == 0) begin
                res.status = STAT_ZERO;
            end else begin
                mag = int_sqrt(sum_sq);
                for (int i = 0; i < 4; i++) begin
                    acc[i] = rq.a[i];
                    scaled = (acc[i] < 0 ? -acc[i] : acc[i]) << FRAC_BITS;
                    quo = (2 * scaled + mag) / (2 * mag);
                    res.q[i] = clamp16(acc[i] < 0 ? -longint'(quo) : longint'(quo), ovf);
                end
            end
        end else begin
            res.q[0] = rq.a[0];
            for (int i = 1; i < 4; i++) res.q[i] = clamp16(-longint'(rq.a[i]), ovf);
        end
        if (res.status == STAT_OK && ovf) res.status = STAT_SAT;
        return res;
    endfunction

    function automatic comp_t rand_comp();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3, 4, 5: return comp_t'(int'($urandom_range(0, 8192)) - 4096);
            default: return comp_t'($urandom);
        endcase
    endfunction

    // flow control on the sender side
    int burst_left = 0;

    task automatic send_request(input quat_req_t rq, input quat_res_t expd);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_kind  <= rq.kind;
        s_a_w <= rq.a[0]; s_a_x <= rq.a[1]; s_a_y <= rq.a[2]; s_a_z <= rq.a[3];
        s_b_w <= rq.b[0]; s_b_x <= rq.b[1]; s_b_y <= rq.b[2]; s_b_z <= rq.b[3];
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(expd);
        n_kind[rq.kind]++;
    endtask

    // receiver stall pattern: modes change every so often
    int stall_mode = 0;
    int mode_left = 0;
    always @(negedge aclk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 1) != 0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        quat_res_t expd;
        comp_t     got[4];
        if (aresetn && m_valid && m_ready) begin
            got = '{m_res_w, m_res_x, m_res_y, m_res_z};
            n_results++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d status=%0d",
                         $time, m_res_w, m_res_x, m_res_y, m_res_z, m_status);
                n_errors++;
            end else begin
                expd = pending_results.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (got[i] !== expd.q[i]) begin
                        $display("%0t: component %0d expected %0d got %0d",
                                 $time, i, expd.q[i], got[i]);
                        n_errors++;
                    end
                end
                if (m_status !== expd.status) begin
                    $display("%0t: status expected %0d got %0d", $time, expd.status, m_status);
                    n_errors++;
                end
                if (expd.status == STAT_SAT) n_sat++;
                if (expd.status == STAT_ZERO) n_zero++;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
        $display("Verification failed");
        $finish;
    end

    initial begin
        quat_req_t rq;
        quat_res_t expd;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[n]) begin
            rq.kind = dir_rows[n].kind;
            for (int i = 0; i < 4; i++) begin
                rq.a[i] = comp_t'(dir_rows[n].a[i]);
                rq.b[i] = comp_t'(dir_rows[n].b[i]);
            end
            if (dir_rows[n].lit) begin
                for (int i = 0; i < 4; i++) expd.q[i] = comp_t'(dir_rows[n].r[i]);
                expd.status = dir_rows[n].st;
            end else begin
                expd = quat_compute(rq);
            end
            send_request(rq, expd);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            // drain once midway
            if (n == N_RANDOM / 2) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                wait (pending_results.size() == 0);
            end
            rq.kind = $urandom_range(0, 15) == 0 ? KIND_UNDEF : 2'($urandom_range(0, 2));
            for (int i = 0; i < 4; i++) begin
                rq.a[i] = rand_comp();
                rq.b[i] = rand_comp();
            end
            if (rq.kind == KIND_NORM && $urandom_range(0, 19) == 0) rq.a = '{0, 0, 0, 0};
            send_request(rq, quat_compute(rq));
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (60) @(posedge aclk);
        $display("Checked %0d results: %0d product, %0d conjugate, %0d normalize, %0d kind 3",
                 n_results, n_kind[0], n_kind[1], n_kind[2], n_kind[3]);
        $display("  of which %0d saturated and %0d zero-magnitude", n_sat, n_zero);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/qau_pkg.sv
sv/quaternion_arith_unit_top.sv
bench/quaternion_arith_unit_top_test.sv
